FILE: hw/rtl/keypad_matrix_scanner_assert.svh
// assertion macros shared by the checker file
`ifndef KEYPAD_MATRIX_SCANNER_ASSERT_SVH
`define KEYPAD_MATRIX_SCANNER_ASSERT_SVH

// same-cycle implication, held off while in reset
`define KMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kms_pkg.sv
`default_nettype none

package kms_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 3;

    localparam logic [2:0]  COL_IDLE       = 3'b111;
    localparam logic [3:0]  ROW_ALL_LOW    = 4'b0000;
    localparam logic [3:0]  ROW_MASK       = 4'b1111;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

    localparam logic [1:0] MODE_TICK         = 2'd0;
    localparam logic [1:0] MODE_READ         = 2'd1;
    localparam logic [1:0] MODE_READ_TIMEOUT = 2'd2;

    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_KEY      = 2'd1;
    localparam logic [1:0] STATUS_NOT_IDLE = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

    localparam logic [6:0] CHAR_NOT_IDLE = 7'h45;
    localparam logic [6:0] CHAR_TIMEOUT  = 7'h54;
    localparam logic [6:0] CHAR_UNKNOWN  = 7'h3f;
    localparam logic [3:0] KEY_CODE_MAX  = 4'd11;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  col_levels;
        logic [15:0] timeout_ms;
    } kms_item_t;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       done_res;
        logic [1:0] status;
        logic [3:0] key_code;
        logic [6:0] key_char;
        logic       busy_res;
    } kms_result_t;

    // fixed telephone-style keymap, row major
    function automatic logic [6:0] kms_key_char(input logic [3:0] code);
        logic [6:0] ch;
        case (code)
            4'd0:    ch = 7'h31;
            4'd1:    ch = 7'h32;
            4'd2:    ch = 7'h33;
            4'd3:    ch = 7'h34;
            4'd4:    ch = 7'h35;
            4'd5:    ch = 7'h36;
            4'd6:    ch = 7'h37;
            4'd7:    ch = 7'h38;
            4'd8:    ch = 7'h39;
            4'd9:    ch = 7'h2a;
            4'd10:   ch = 7'h30;
            4'd11:   ch = 7'h23;
            default: ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kms_if.sv
`default_nettype none

interface kms_sample_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  col_levels;
    logic [15:0] timeout_ms;

    modport source (output valid, output mode, output col_levels, output timeout_ms,
                    input ready);
    modport sink   (input valid, input mode, input col_levels, input timeout_ms,
                    output ready);
endinterface

interface kms_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_drive;
    logic       done_res;
    logic [1:0] status;
    logic [3:0] key_code;
    logic [6:0] key_char;
    logic       busy_res;

    modport source (output valid, output row_drive, output done_res, output status,
                    output key_code, output key_char, output busy_res, input ready);
    modport sink   (input valid, input row_drive, input done_res, input status,
                    input key_code, input key_char, input busy_res, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/keypad_matrix_scanner.sv
// keypad matrix scanner for a 4x3 key matrix
// sample: one transaction per 1 ms tick with mode, sampled column levels and
//   the press timeout; mode 1 starts a read, mode 2 a read with timeout,
//   anything else is a plain tick
// result: one transaction per sample with the row levels to drive before the
//   next sample, a done flag, status, key code, key character and busy flag
// cfg_we / cfg_wdata: writes the debounce length in ticks
// path: a sample accepted into the input register passes through the core logic
//   into the result register, which drives the result channel
// throughput: one sample per cycle while results are taken; the per-tick state
//   update is a single pass of logic between the two registers
// reset: the scanner goes idle, all counters clear and the debounce length
//   returns to 20 ticks; rows are driven low between requests
// stall: a held result keeps its register; the input register still takes
//   one more sample, then sample ready drops until the result is taken
`default_nettype none

module keypad_matrix_scanner
    import kms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    kms_sample_if.sink       sample,
    kms_result_if.source     result,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    logic        in_valid_reg, in_valid_next;
    kms_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    kms_result_t out_res_reg;
    logic [15:0] debounce_reg;

    logic        advance;
    logic        take;
    kms_result_t step_res;

    assign advance        = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready   = !in_valid_reg || advance;
    assign take           = sample.valid && sample.ready;
    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    kms_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .item           (in_item_reg),
        .debounce_ticks (debounce_reg),
        .res            (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                debounce_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.mode       <= sample.mode;
            in_item_reg.col_levels <= sample.col_levels;
            in_item_reg.timeout_ms <= sample.timeout_ms;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign result.valid     = out_valid_reg;
    assign result.row_drive = out_res_reg.row_drive;
    assign result.done_res  = out_res_reg.done_res;
    assign result.status    = out_res_reg.status;
    assign result.key_code  = out_res_reg.key_code;
    assign result.key_char  = out_res_reg.key_char;
    assign result.busy_res  = out_res_reg.busy_res;

endmodule

`default_nettype wire

FILE: hw/rtl/kms_core.sv
`default_nettype none

module kms_core
    import kms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire kms_item_t   item,
    input  wire logic [15:0] debounce_ticks,
    output kms_result_t      res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_PRESS,
        PH_SETTLE_PRESS,
        PH_SCAN,
        PH_WAIT_RELEASE,
        PH_SETTLE_RELEASE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] settle_reg, settle_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] limit_reg, limit_next;
    logic        limit_en_reg, limit_en_next;
    logic [1:0]  col_reg, col_next;
    logic [1:0]  scan_row_reg, scan_row_next;
    logic [1:0]  found_row_reg, found_row_next;

    logic        cols_idle;
    logic [1:0]  high_low_col;
    logic [1:0]  scan_row_inc;
    logic [15:0] settle_inc;
    logic [15:0] elapsed_inc;
    logic [3:0]  code;

    assign cols_idle    = (item.col_levels == COL_IDLE);
    assign scan_row_inc = scan_row_reg + 2'd1;
    assign settle_inc   = settle_reg + 16'd1;
    assign elapsed_inc  = elapsed_reg + 16'd1;
    assign code         = ({2'b00, found_row_reg} << 1) + {2'b00, found_row_reg}
                          + {2'b00, col_reg};

    // highest-numbered low column wins
    always_comb
    begin
        priority if (!item.col_levels[2])
            high_low_col = 2'd2;
        else if (!item.col_levels[1])
            high_low_col = 2'd1;
        else
            high_low_col = 2'd0;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        settle_next    = settle_reg;
        elapsed_next   = elapsed_reg;
        limit_next     = limit_reg;
        limit_en_next  = limit_en_reg;
        col_next       = col_reg;
        scan_row_next  = scan_row_reg;
        found_row_next = found_row_reg;
        res            = '0;
        res.row_drive  = ROW_ALL_LOW;

        unique case (phase_reg)
            PH_WAIT_PRESS:
            begin
                if (!cols_idle)
                begin
                    settle_next = '0;
                    phase_next  = PH_SETTLE_PRESS;
                end
                else if (limit_en_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= limit_reg)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_TIMEOUT;
                        res.key_char = CHAR_TIMEOUT;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            PH_SETTLE_PRESS:
            begin
                if (settle_reg < debounce_ticks)
                    settle_next = settle_inc;
                else
                begin
                    col_next      = high_low_col;
                    scan_row_next = '0;
                    phase_next    = PH_SCAN;
                    res.row_drive = ROW_MASK & ~4'b0001;
                end
            end
            PH_SCAN:
            begin
                if (!item.col_levels[col_reg])
                begin
                    found_row_next = scan_row_reg;
                    phase_next     = PH_WAIT_RELEASE;
                end
                else if (scan_row_reg == 2'(ROWS - 1))
                begin
                    found_row_next = '0;
                    phase_next     = PH_WAIT_RELEASE;
                end
                else
                begin
                    scan_row_next = scan_row_inc;
                    res.row_drive = ROW_MASK & ~(4'b0001 << scan_row_inc);
                end
            end
            PH_WAIT_RELEASE:
            begin
                if (cols_idle)
                begin
                    settle_next = '0;
                    phase_next  = PH_SETTLE_RELEASE;
                end
            end
            PH_SETTLE_RELEASE:
            begin
                if (settle_reg < debounce_ticks)
                    settle_next = settle_inc;
                else
                begin
                    res.done_res = 1'b1;
                    res.status   = STATUS_KEY;
                    res.key_code = code;
                    res.key_char = kms_key_char(code);
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                if (item.mode == MODE_READ)
                begin
                    if (!cols_idle)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_NOT_IDLE;
                        res.key_char = CHAR_NOT_IDLE;
                    end
                    else
                    begin
                        limit_en_next = 1'b0;
                        elapsed_next  = '0;
                        phase_next    = PH_WAIT_PRESS;
                    end
                end
                else if (item.mode == MODE_READ_TIMEOUT)
                begin
                    if (item.timeout_ms == '0)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_TIMEOUT;
                        res.key_char = CHAR_TIMEOUT;
                    end
                    else
                    begin
                        limit_en_next = 1'b1;
                        limit_next    = item.timeout_ms;
                        elapsed_next  = '0;
                        phase_next    = PH_WAIT_PRESS;
                    end
                end
            end
        endcase

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            settle_reg    <= '0;
            elapsed_reg   <= '0;
            limit_reg     <= '0;
            limit_en_reg  <= 1'b0;
            col_reg       <= '0;
            scan_row_reg  <= '0;
            found_row_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            settle_reg    <= settle_next;
            elapsed_reg   <= elapsed_next;
            limit_reg     <= limit_next;
            limit_en_reg  <= limit_en_next;
            col_reg       <= col_next;
            scan_row_reg  <= scan_row_next;
            found_row_reg <= found_row_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/kms_checker.sv
`default_nettype none
`include "keypad_matrix_scanner_assert.svh"

module kms_checker
    import kms_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [3:0] row_drive,
    input wire logic       done_res,
    input wire logic [1:0] status,
    input wire logic [3:0] key_code,
    input wire logic [6:0] key_char,
    input wire logic       busy_res
);

    // a stalled result transaction holds
    `KMS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({row_drive, done_res, status, key_code, key_char, busy_res}), "result changed while stalled")

    // done goes with a real status and ends the request
    `KMS_ASSERT_IMPLY(a_done_status, clk, rst_n, res_valid, (done_res == (status != STATUS_NONE)) && !(done_res && busy_res), "done flag and status disagree")

    // a key read carries a code inside the keymap
    `KMS_ASSERT_IMPLY(a_key_code, clk, rst_n, res_valid && status == STATUS_KEY, key_code <= KEY_CODE_MAX && key_char != CHAR_UNKNOWN, "key code outside keymap")

    // error results carry their marker character and no code
    `KMS_ASSERT_IMPLY(a_err_char, clk, rst_n, res_valid && (status == STATUS_NOT_IDLE || status == STATUS_TIMEOUT), key_code == '0 && (key_char == CHAR_NOT_IDLE || key_char == CHAR_TIMEOUT), "error result malformed")

    // rows all low, or exactly one low while a scan is running
    `KMS_ASSERT_IMPLY(a_row_drive, clk, rst_n, res_valid && row_drive != ROW_ALL_LOW, busy_res && $countones(row_drive) == ROWS - 1, "row drive pattern invalid")

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .row_drive (result.row_drive),
    .done_res  (result.done_res),
    .status    (result.status),
    .key_code  (result.key_code),
    .key_char  (result.key_char),
    .busy_res  (result.busy_res)
);

`default_nettype wire

FILE: tb/sv/keypad_matrix_scanner_tb.sv
module keypad_matrix_scanner_tb;
    import kms_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RESULT_HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORK_PER_SETTING = 300;
    localparam logic [7:0] KEY_GLYPH [12] =
        '{"1", "2", "3", "4", "5", "6", "7", "8", "9", "*", "0", "#"};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AWAIT_PRESS,
        ST_PRESS_SETTLE,
        ST_ROW_SCAN,
        ST_AWAIT_RELEASE,
        ST_RELEASE_SETTLE
    } scan_phase_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    kms_sample_if sample_ch ();
    kms_result_if result_ch ();

    keypad_matrix_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // scanner state as the testbench sees it
    scan_phase_t scan_phase;
    logic [15:0] debounce_len;
    logic [15:0] settle_cnt;
    logic [15:0] wait_cnt;
    logic [15:0] wait_max;
    logic        wait_limited;
    logic [1:0]  key_col;
    logic [2:0]  probe_row;
    logic [1:0]  key_row;
    logic [3:0]  last_row_drive;

    kms_result_t expected_results [$];
    int          fail_count = 0;
    int          worked_items = 0;
    int          sample_idle_pct = 10;
    int          result_idle_pct = 10;
    bit          hold_results = 1'b0;
    int          quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic kms_result_t predict_scan(input kms_item_t it);
        kms_result_t r;
        int          c;
        int          code;
        r = '0;
        case (scan_phase)
            ST_IDLE:
            begin
                if (it.mode == MODE_READ)
                begin
                    if (it.col_levels != COL_IDLE)
                    begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_NOT_IDLE;
                        r.key_char = CHAR_NOT_IDLE;
                    end
                    else
                    begin
                        wait_limited = 1'b0;
                        wait_cnt     = '0;
                        scan_phase   = ST_AWAIT_PRESS;
                    end
                end
                else if (it.mode == MODE_READ_TIMEOUT)
                begin
                    if (it.timeout_ms == '0)
                    begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_TIMEOUT;
                        r.key_char = CHAR_TIMEOUT;
                    end
                    else
                    begin
                        wait_limited = 1'b1;
                        wait_max     = it.timeout_ms;
                        wait_cnt     = '0;
                        scan_phase   = ST_AWAIT_PRESS;
                    end
                end
            end
            ST_AWAIT_PRESS:
            begin
                if (it.col_levels != COL_IDLE)
                begin
                    settle_cnt = '0;
                    scan_phase = ST_PRESS_SETTLE;
                end
                else if (wait_limited)
                begin
                    wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= wait_max)
                    begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_TIMEOUT;
                        r.key_char = CHAR_TIMEOUT;
                        scan_phase = ST_IDLE;
                    end
                end
            end
            ST_PRESS_SETTLE:
            begin
                if (settle_cnt < debounce_len)
                    settle_cnt = settle_cnt + 16'd1;
                else
                begin
                    // highest low column wins, none low gives column 0
                    key_col = '0;
                    for (c = 0; c < COLS; c++)
                        if (!it.col_levels[c])
                            key_col = 2'(c);
                    probe_row   = '0;
                    scan_phase  = ST_ROW_SCAN;
                    r.row_drive = ROW_MASK & ~4'b0001;
                end
            end
            ST_ROW_SCAN:
            begin
                if (!it.col_levels[key_col])
                begin
                    key_row    = probe_row[1:0];
                    scan_phase = ST_AWAIT_RELEASE;
                end
                else if (int'(probe_row) + 1 >= ROWS)
                begin
                    key_row    = '0;
                    scan_phase = ST_AWAIT_RELEASE;
                end
                else
                begin
                    probe_row   = probe_row + 3'd1;
                    r.row_drive = ROW_MASK & ~(4'b0001 << probe_row);
                end
            end
            ST_AWAIT_RELEASE:
            begin
                if (it.col_levels == COL_IDLE)
                begin
                    settle_cnt = '0;
                    scan_phase = ST_RELEASE_SETTLE;
                end
            end
            default:
            begin
                if (settle_cnt < debounce_len)
                    settle_cnt = settle_cnt + 16'd1;
                else
                begin
                    code       = int'(key_row) * COLS + int'(key_col);
                    r.done_res = 1'b1;
                    r.status   = STATUS_KEY;
                    r.key_code = 4'(code);
                    r.key_char = (code <= int'(KEY_CODE_MAX)) ? KEY_GLYPH[code][6:0]
                                                              : CHAR_UNKNOWN;
                    scan_phase = ST_IDLE;
                end
            end
        endcase
        r.busy_res     = (scan_phase != ST_IDLE);
        last_row_drive = r.row_drive;
        return r;
    endfunction

    // column levels seen with one key held, under the rows driven last
    function automatic logic [2:0] keypad_cols(input int krow, input int kcol);
        logic [2:0] c;
        c = COL_IDLE;
        if (krow >= 0 && !last_row_drive[krow])
            c[kcol] = 1'b0;
        return c;
    endfunction

    task automatic send_sample(input logic [1:0] mode, input logic [2:0] cols,
                               input logic [15:0] tmo);
        kms_item_t it;
        it = '{mode: mode, col_levels: cols, timeout_ms: tmo};
        @(negedge clk);
        while ($urandom_range(99) < sample_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.mode       <= mode;
        sample_ch.col_levels <= cols;
        sample_ch.timeout_ms <= tmo;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        if (scan_phase != ST_IDLE || mode == MODE_READ || mode == MODE_READ_TIMEOUT)
            worked_items++;
        expected_results.push_back(predict_scan(it));
    endtask

    task automatic drain_results();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] ticks);
        drain_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(negedge clk);
        cfg_we       <= 1'b0;
        debounce_len = ticks;
    endtask

    // plays a key on the matrix until the running request ends
    // release_at: 0 clean press, 1 gone before the press settles, 2 gone during the scan
    task automatic play_keypad(input int krow, input int kcol, input int wait_n,
                               input int hold_n, input int release_at, input int bounce_pct);
        int         waited;
        int         held_for;
        bit         held;
        logic [2:0] cols;
        waited   = 0;
        held_for = 0;
        while (scan_phase != ST_IDLE)
        begin
            case (scan_phase)
                ST_AWAIT_PRESS:
                begin
                    held = (krow >= 0) && (waited >= wait_n);
                    waited++;
                end
                ST_PRESS_SETTLE:  held = (release_at != 1);
                ST_ROW_SCAN:      held = (release_at == 0);
                ST_AWAIT_RELEASE:
                begin
                    held = (release_at == 0) && (held_for < hold_n);
                    held_for++;
                end
                default:          held = 1'b0;
            endcase
            cols = held ? keypad_cols(krow, kcol) : COL_IDLE;
            if ($urandom_range(99) < bounce_pct)
                cols = 3'($urandom);
            send_sample(2'($urandom), cols, 16'($urandom));
        end
    endtask

    task automatic key_read(input logic [1:0] mode, input logic [15:0] tmo, input int krow,
                            input int kcol, input int wait_n, input int release_at);
        send_sample(mode, COL_IDLE, tmo);
        play_keypad(krow, kcol, wait_n, 2, release_at, 0);
    endtask

    task automatic test_idle_ticks();
        send_sample(MODE_TICK, 3'b000, 16'h0000);
        send_sample(MODE_TICK, COL_IDLE, 16'hffff);
        send_sample(MODE_UNUSED, 3'b010, 16'h5555);
        send_sample(MODE_UNUSED, COL_IDLE, 16'haaaa);
    endtask

    task automatic test_busy_columns();
        int c;
        for (c = 0; c < 7; c++)
            send_sample(MODE_READ, 3'(c), 16'($urandom));
    endtask

    task automatic test_zero_timeout();
        send_sample(MODE_READ_TIMEOUT, COL_IDLE, 16'h0000);
        send_sample(MODE_READ_TIMEOUT, 3'b000, 16'h0000);
    endtask

    task automatic test_reset_debounce();
        key_read(MODE_READ, 16'h0000, 1, 1, 2, 0);
    endtask

    task automatic test_key_corners();
        key_read(MODE_READ, 16'h0000, 0, 0, 0, 0);
        key_read(MODE_READ, 16'h0000, 3, 2, 1, 0);
        key_read(MODE_READ, 16'h0000, 3, 0, 0, 0);
        send_sample(MODE_READ_TIMEOUT, 3'b000, 16'hffff);
        play_keypad(0, 2, 1, 0, 0, 0);
    endtask

    task automatic test_timeouts();
        key_read(MODE_READ_TIMEOUT, 16'd1, -1, 0, 0, 0);
        key_read(MODE_READ_TIMEOUT, 16'd5, -1, 0, 0, 0);
        key_read(MODE_READ_TIMEOUT, 16'd3, 2, 1, 2, 0);
    endtask

    task automatic test_release_glitches();
        key_read(MODE_READ, 16'h0000, 2, 2, 1, 1);
        key_read(MODE_READ, 16'h0000, 1, 2, 1, 2);
    endtask

    task automatic test_two_columns();
        send_sample(MODE_READ, COL_IDLE, 16'h0000);
        send_sample(MODE_TICK, 3'b100, 16'h0000);
        send_sample(MODE_TICK, 3'b100, 16'h0000);
        play_keypad(0, 1, 0, 1, 0, 0);
    endtask

    task automatic test_backpressure();
        int n;
        write_debounce(16'd3);
        send_sample(MODE_READ, COL_IDLE, 16'h0000);
        hold_results = 1'b1;
        for (n = 0; n < 80; n++)
            send_sample(MODE_TICK, COL_IDLE, 16'($urandom));
        drain_results();
        play_keypad(3, 1, 4, 3, 0, 5);
    endtask

    task automatic random_key_read();
        logic [1:0]  mode;
        logic [15:0] tmo;
        int          krow;
        int          kcol;
        int          release_at;
        mode = $urandom_range(1) ? MODE_READ_TIMEOUT : MODE_READ;
        tmo  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 30));
        krow = $urandom_range(0, 3);
        kcol = $urandom_range(0, 2);
        if (mode == MODE_READ_TIMEOUT && tmo <= 16'd30 && $urandom_range(4) == 0)
            krow = -1;
        release_at = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
        send_sample(mode, (mode == MODE_READ_TIMEOUT) ? 3'($urandom) : COL_IDLE, tmo);
        play_keypad(krow, kcol, $urandom_range(0, 25), $urandom_range(0, 6), release_at,
                    $urandom_range(1) ? 0 : $urandom_range(1, 15));
    endtask

    task automatic test_random_reads();
        int setting;
        int start;
        for (setting = 0; setting < 4; setting++)
        begin
            case (setting)
                0:       write_debounce(16'd1);
                1:       write_debounce(16'd0);
                2:       write_debounce(16'd7);
                default: write_debounce(16'($urandom_range(2, 12)));
            endcase
            // one whole setting with both sides flat out
            sample_idle_pct = (setting == 1) ? 0 : 10;
            result_idle_pct = (setting == 1) ? 0 : 10;
            start = worked_items;
            while (worked_items - start < RANDOM_WORK_PER_SETTING)
            begin
                if ($urandom_range(99) < 85)
                    random_key_read();
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_sample(2'($urandom), 3'($urandom), 16'($urandom));
                    play_keypad($urandom_range(0, 3), $urandom_range(0, 2),
                                $urandom_range(0, 10), $urandom_range(0, 4), 0, 10);
                end
            end
        end
        sample_idle_pct = 10;
        result_idle_pct = 10;
    endtask

    task automatic test_extremes();
        write_debounce(16'd40);
        key_read(MODE_READ, 16'h0000, 2, 2, 0, 0);
        // longest timeout, key arrives well before it runs out
        key_read(MODE_READ_TIMEOUT, 16'hffff, 3, 2, 8, 0);
        write_debounce(DEBOUNCE_RESET);
        key_read(MODE_READ, 16'h0000, 1, 0, 3, 0);
    endtask

    task automatic check_field(input string name, input int unsigned exp,
                               input int unsigned got);
        if (exp != got)
        begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        kms_result_t exp;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                exp = expected_results.pop_front();
                check_field("row_drive", 32'(exp.row_drive), 32'(result_ch.row_drive));
                check_field("done_res", 32'(exp.done_res), 32'(result_ch.done_res));
                check_field("status", 32'(exp.status), 32'(result_ch.status));
                check_field("key_code", 32'(exp.key_code), 32'(result_ch.key_code));
                check_field("key_char", 32'(exp.key_char), 32'(result_ch.key_char));
                check_field("busy_res", 32'(exp.busy_res), 32'(result_ch.busy_res));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("keypad_matrix_scanner test failed");
            $finish;
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= result_idle_pct);
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.mode       = MODE_TICK;
        sample_ch.col_levels = COL_IDLE;
        sample_ch.timeout_ms = '0;
        scan_phase           = ST_IDLE;
        debounce_len         = DEBOUNCE_RESET;
        settle_cnt           = '0;
        wait_cnt             = '0;
        wait_max             = '0;
        wait_limited         = 1'b0;
        key_col              = '0;
        probe_row            = '0;
        key_row              = '0;
        last_row_drive       = ROW_ALL_LOW;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_busy_columns();
        test_zero_timeout();
        test_reset_debounce();
        write_debounce(16'd0);
        test_key_corners();
        test_timeouts();
        test_release_glitches();
        test_two_columns();
        test_backpressure();
        test_random_reads();
        test_extremes();

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("keypad_matrix_scanner test passed");
        else
            $display("keypad_matrix_scanner test failed");
        $finish;
    end

endmodule
